@@ design/assert_macros.svh @@
// --------------------------------------------------------------------------
// assertion macros
// shared clocked assertion forms for the checker
// --------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/xbr_pkg.sv @@
// --------------------------------------------------------------------------
// xbr_pkg
// constants and types of the bounded xoshiro256++ generator
// --------------------------------------------------------------------------
package xbr_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A    = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94d049bb133111eb;

  typedef struct packed {
    logic [63:0] raw;
    logic [31:0] bound;
  } q_item_t;

endpackage

@@ design/xbr_front.sv @@
// --------------------------------------------------------------------------
// xbr_front
// seed expansion, state advance and draw issue into the queue
// --------------------------------------------------------------------------
module xbr_front import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_bound,
  output logic        q_push,
  output q_item_t     q_item,
  input  logic        q_full
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_GEN  = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic        seeded_r;
  logic [63:0] seed_r, acc_r, z_r, prod_r;
  logic [1:0]  mcnt_r, widx_r;
  logic [31:0] bound_r;
  logic [63:0] w_r [4];

  logic        accept, cfg_wr;
  logic [63:0] acc_nxt, kmul, psum;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [63:0] t, raw, n0, n1, n2, n3;

  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || q_full;
  assign accept    = in_valid && !in_stall;

  assign kmul  = (state_r == ST_MUL2) ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a = (mcnt_r == 2'd1) ? z_r[63:32] : z_r[31:0];
  assign mul_b = (mcnt_r == 2'd2) ? kmul[63:32] : kmul[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign psum  = (mcnt_r == 2'd0) ? prod : prod_r + {prod[31:0], 32'd0};

  assign acc_nxt = (accept ? seed_r : acc_r) + GOLDEN_GAMMA;

  // xoshiro256++ output and update
  assign t   = w_r[0] + w_r[3];
  assign raw = {t[40:0], t[63:41]} + w_r[0];
  assign n2  = w_r[2] ^ w_r[0];
  assign n3  = w_r[3] ^ w_r[1];
  assign n1  = w_r[1] ^ n2;
  assign n0  = w_r[0] ^ n3;

  assign q_push       = (accept && seeded_r) || (state_r == ST_GEN);
  assign q_item.raw   = raw;
  assign q_item.bound = (state_r == ST_GEN) ? bound_r : in_bound;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && !seeded_r) state_nxt = ST_MUL1;
      ST_MUL1: if (mcnt_r == 2'd2) state_nxt = ST_MUL2;
      ST_MUL2: if (mcnt_r == 2'd2) state_nxt = (widx_r == 2'd3) ? ST_GEN : ST_MUL1;
      ST_GEN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      seeded_r <= 1'b0;
      seed_r   <= '0;
      mcnt_r   <= '0;
      widx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        seed_r   <= cfg_seed;
        seeded_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          mcnt_r <= '0;
          widx_r <= '0;
        end
        ST_MUL1, ST_MUL2: begin
          mcnt_r <= (mcnt_r == 2'd2) ? 2'd0 : mcnt_r + 2'd1;
          if (state_r == ST_MUL2 && mcnt_r == 2'd2) begin
            widx_r <= widx_r + 2'd1;
            if (widx_r == 2'd3) seeded_r <= 1'b1;
          end
        end
        default: mcnt_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) bound_r <= in_bound;
    if (accept && !seeded_r) begin
      acc_r <= acc_nxt;
      z_r   <= acc_nxt ^ (acc_nxt >> 30);
    end
    if (state_r == ST_MUL1 || state_r == ST_MUL2) prod_r <= psum;
    if (state_r == ST_MUL1 && mcnt_r == 2'd2) z_r <= psum ^ (psum >> 27);
    if (state_r == ST_MUL2 && mcnt_r == 2'd2) begin
      w_r[widx_r] <= psum ^ (psum >> 31);
      acc_r       <= acc_nxt;
      z_r         <= acc_nxt ^ (acc_nxt >> 30);
    end
    if (q_push) begin
      w_r[0] <= n0;
      w_r[1] <= n1;
      w_r[2] <= n2 ^ {w_r[1][46:0], 17'd0};
      w_r[3] <= {n3[18:0], n3[63:19]};
    end
  end

endmodule

@@ design/xbr_queue.sv @@
// --------------------------------------------------------------------------
// xbr_queue
// two-entry queue between issue and reduction
// --------------------------------------------------------------------------
module xbr_queue import xbr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output q_item_t pop_item,
  output logic    empty
);

  q_item_t    mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
  end

endmodule

@@ design/xbr_back.sv @@
// --------------------------------------------------------------------------
// xbr_back
// radix-4 restoring modulo and output register
// --------------------------------------------------------------------------
module xbr_back import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  q_item_t     q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_raw_value,
  output logic [31:0] out_bounded_value
);

  logic        busy_r, ovalid_r;
  logic [4:0]  cnt_r;
  logic [63:0] raw_r, dvd_r;
  logic [31:0] bound_r, rem_r, oval_r;
  logic [63:0] oraw_r;
  logic [32:0] s1, s2;
  logic [31:0] r1, r2;
  logic        done, out_free;

  assign s1 = {rem_r, dvd_r[63]};
  assign r1 = (s1 >= {1'b0, bound_r}) ? 32'(s1 - {1'b0, bound_r}) : s1[31:0];
  assign s2 = {r1, dvd_r[62]};
  assign r2 = (s2 >= {1'b0, bound_r}) ? 32'(s2 - {1'b0, bound_r}) : s2[31:0];

  assign out_free = !ovalid_r || !out_stall;
  assign done     = busy_r && (cnt_r == 5'd0) && out_free;
  assign q_pop    = !busy_r && !q_empty;

  assign out_valid         = ovalid_r;
  assign out_raw_value     = oraw_r;
  assign out_bounded_value = oval_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (q_pop) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (done) begin
        busy_r   <= 1'b0;
        ovalid_r <= 1'b1;
      end else if (busy_r && cnt_r != 5'd0) begin
        cnt_r <= cnt_r - 5'd1;
      end
    end
  end

  // the last two dividend bits are reduced as the result is registered
  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw_r   <= q_item.raw;
      dvd_r   <= q_item.raw;
      bound_r <= q_item.bound;
      rem_r   <= '0;
    end else if (busy_r && cnt_r != 5'd0) begin
      rem_r <= r2;
      dvd_r <= {dvd_r[61:0], 2'b00};
    end
    if (done) begin
      oraw_r <= raw_r;
      oval_r <= (bound_r == 32'd0) ? 32'd0 : r2;
    end
  end

endmodule

@@ design/xoshiro256pp_bounded_random.sv @@
// --------------------------------------------------------------------------
// xoshiro256pp_bounded_random
// xoshiro256++ draws with splitmix64 seeding and a modulo by the bound
// --------------------------------------------------------------------------
// usage
//   cfg_valid/cfg_ready/cfg_seed writes the 64-bit seed; ready only while
//   the front is idle. a write marks the generator unseeded.
//   in_valid/in_stall/in_bound requests one draw; out_valid/out_stall
//   returns out_raw_value and out_bounded_value (raw mod bound, 0 for 0).
//   the first draw after a seed write goes through seed expansion:
//   four splitmix64 steps, each two 64-bit products built from three
//   32x32 partial products in one shared multiplier.
//   a seeded draw enters the queue in the cycle it is taken; the back end
//   reduces modulo the bound two quotient bits a cycle, the last step
//   waiting while a stalled result holds the output register, and takes
//   the next draw from the queue only once the last one is reduced.
//   the two-entry queue lets draws be taken while the divider works.
//   reset clears the seed to 0 and the seeded flag; no clearing pass.
//   a stalled result holds in the output register; once the queue fills,
//   in_stall rises.
// --------------------------------------------------------------------------
module xoshiro256pp_bounded_random import xbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_bound,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_raw_value,
  output logic [31:0] out_bounded_value
);

  logic    q_push, q_full, q_pop, q_empty;
  q_item_t q_in, q_out;

  xbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_seed  (cfg_seed),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_bound  (in_bound),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  xbr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .empty     (q_empty)
  );

  xbr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_item            (q_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_raw_value     (out_raw_value),
    .out_bounded_value (out_bounded_value)
  );

endmodule

@@ design/xbr_checker.sv @@
// --------------------------------------------------------------------------
// xbr_checker
// port-level checks of the bounded generator
// --------------------------------------------------------------------------
`include "assert_macros.svh"

module xbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_ready,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_raw_value,
  input logic [31:0] out_bounded_value
);

  `ASSERT_ALWAYS(a_rst_no_out, clk, !rst_n |=> !out_valid, "result after reset")
  `ASSERT_ALWAYS(a_rst_cfg_rdy, clk, !rst_n |=> cfg_ready, "seed port not ready after reset")
  `ASSERT_CLK(a_busy_stalls, clk, rst_n, !cfg_ready |-> in_stall, "draw taken during seeding")
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_raw_value) && $stable(out_bounded_value),
    "stalled result changed")

endmodule

bind xoshiro256pp_bounded_random xbr_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_ready         (cfg_ready),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_raw_value     (out_raw_value),
  .out_bounded_value (out_bounded_value)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// --------------------------------------------------------------------------
// testbench
// checks the bounded xoshiro256++ generator against a predictor of its own:
// seeding from reset, seed writes at the extremes, directed and random
// bounds under random idling on both sides, and a long output hold-off
// --------------------------------------------------------------------------
module testbench;
  import xbr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_seed = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_bound = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_raw_value;
  logic [31:0] out_bounded_value;

  logic [63:0] seed_reg;
  logic [63:0] gen_words [4];
  logic        seeded;
  logic [63:0] raw_q [$];
  logic [31:0] bounded_q [$];
  int          err_count = 0;
  bit          idle_on = 1'b1;
  int          hold_cycles = 0;
  int          rx_gap = 0;

  xoshiro256pp_bounded_random uut (.*);

  always #2 clk = ~clk;

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [63:0] rotl(logic [63:0] v, int amt);
    return (v << amt) | (v >> (64 - amt));
  endfunction

  function automatic logic [63:0] splitmix(ref logic [63:0] acc);
    logic [63:0] z;
    acc = acc + GOLDEN_GAMMA;
    z = acc;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    return z ^ (z >> 31);
  endfunction

  // works out the draw for one accepted bound and queues it
  task automatic predict_draw(logic [31:0] bound);
    logic [63:0] acc;
    logic [63:0] raw;
    logic [63:0] shifted;
    if (!seeded) begin
      acc = seed_reg;
      for (int i = 0; i < 4; i++) gen_words[i] = splitmix(acc);
      seeded = 1'b1;
    end
    raw = rotl(gen_words[0] + gen_words[3], 23) + gen_words[0];
    shifted = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= shifted;
    gen_words[3] = rotl(gen_words[3], 45);
    raw_q = {raw_q, raw};
    bounded_q = {bounded_q, (bound == 0) ? 32'd0 : 32'(raw % {32'd0, bound})};
  endtask

  task automatic send_draw(logic [31:0] bound);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_bound = bound;
    do @(posedge clk); while (in_stall);
    predict_draw(bound);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (raw_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] value);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_seed = value;
    do @(posedge clk); while (!cfg_ready);
    seed_reg = value;
    seeded = 1'b0;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(1, 16);
      2: return 32'd0;
      3: return 32'd1 << $urandom_range(0, 31);
      4: return 32'hffff_ffff - $urandom_range(0, 7);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: long hold-off when asked, otherwise random stall bursts
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_gap > 0) begin
      out_stall <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      rx_gap <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (raw_q.size() == 0) begin
        $error("unexpected result raw=%h bounded=%h", out_raw_value, out_bounded_value);
        err_count++;
      end else begin
        if (out_raw_value !== raw_q[0]) begin
          $error("raw_value expected %h actual %h", raw_q[0], out_raw_value);
          err_count++;
        end
        if (out_bounded_value !== bounded_q[0]) begin
          $error("bounded_value expected %h actual %h", bounded_q[0], out_bounded_value);
          err_count++;
        end
        void'(raw_q.pop_front());
        void'(bounded_q.pop_front());
      end
    end
  end

  task automatic test_reset_seed();
    logic [31:0] bounds [10] = '{32'd0, 32'd1, 32'd2, 32'hffff_ffff, 32'h8000_0000,
                                32'd3, 32'd7, 32'h7fff_ffff, 32'd10, 32'h5555_aaaa};
    foreach (bounds[i]) send_draw(bounds[i]);
  endtask

  task automatic test_seed_extremes();
    write_seed(64'd0);
    send_draw(32'd0);
    send_draw(32'hffff_ffff);
    write_seed(64'hffff_ffff_ffff_ffff);
    send_draw(32'd1);
    send_draw(32'd13);
    write_seed(64'hffff_ffff_ffff_ffff);
    send_draw(32'hffff_fffe);
    write_seed(64'd1);
    send_draw(32'd6);
    write_seed(64'h8000_0000_0000_0000);
    send_draw(32'h0001_0000);
    send_draw(32'd0);
  endtask

  task automatic test_hold_off();
    write_seed({$urandom, $urandom});
    @(negedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 10; i++) send_draw(pick_bound());
  endtask

  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      write_seed({$urandom, $urandom});
      if (p == 7) idle_on = 1'b0;
      for (int i = 0; i < 230; i++) send_draw(pick_bound());
    end
  endtask

  initial begin
    seed_reg = '0;
    seeded = 1'b0;
    foreach (gen_words[i]) gen_words[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_seed();
    test_seed_extremes();
    test_hold_off();
    test_random();
    drain();
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+design
design/xbr_pkg.sv
design/xbr_front.sv
design/xbr_queue.sv
design/xbr_back.sv
design/xoshiro256pp_bounded_random.sv
design/xbr_checker.sv
dv/testbench.sv
